/* hdl/probabilistic_step_sequencer_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the probabilistic step sequencer
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef PROBABILISTIC_STEP_SEQUENCER_TOP_ASSERT_SVH
`define PROBABILISTIC_STEP_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication
`define PSS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/pss_pkg.sv */
// ----------------------------------------------------------------------------
// Probabilistic step sequencer package
// Field widths, register codes, event type and fixed arithmetic constants.
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int unsigned SPD_W     = 20;
  localparam int unsigned STEPCNT_W = 6;
  localparam int unsigned PROB_W    = 9;
  localparam int unsigned KEY_W     = 7;
  localparam int unsigned VEL_W     = 7;
  localparam int unsigned RAND_W    = 16;
  localparam int unsigned SHIFT_W   = 3;
  localparam int unsigned INDEX_W   = 5;
  localparam int unsigned VFRAC_W   = 9;
  localparam int unsigned CFG_IDX_W = 2;

  // entries a write item can address
  localparam int unsigned TABLE_SLOTS = 32;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_WRITE = 1'b1
  } pss_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLES_PER_DIV = 2'd0,
    REG_STEP_COUNT      = 2'd1,
    REG_BASE_PROB       = 2'd2,
    REG_RANDOMNESS      = 2'd3
  } pss_reg_e;

  typedef struct packed {
    logic             is_note_on;
    logic [KEY_W-1:0] key;
    logic [VEL_W-1:0] velocity;
    logic             last;
  } pss_event_t;

  localparam logic [SPD_W-1:0]     SPD_RESET     = 20'd6000;
  localparam logic [STEPCNT_W-1:0] STEPCNT_RESET = 6'd16;
  localparam logic [PROB_W-1:0]    BASE_RESET    = 9'd128;
  localparam logic [PROB_W-1:0]    RND_RESET     = 9'd0;
  localparam logic [PROB_W-1:0]    RND_HALF      = 9'd128;

  localparam logic [KEY_W-1:0] KEY_RESET = 7'd60;
  localparam logic [KEY_W-1:0] KEY_MAX   = 7'd127;
  localparam logic [VEL_W-1:0] VEL_OFF   = 7'd64;

  localparam logic [SHIFT_W-1:0] SHIFT_WRAP = 3'd7;

  // velocity = floor((889*2^16 + 381*level) / 655360)
  //          = 88 + floor((9 + floor(381*level/2^16)) / 10)
  localparam logic [8:0]       VEL_SLOPE   = 9'd381;
  localparam logic [VEL_W-1:0] VEL_FLOOR   = 7'd88;
  localparam logic [8:0]       VEL_BIAS    = 9'd9;
  localparam logic [7:0]       DIV10_RECIP = 8'd205;
  localparam int unsigned      DIV10_SHIFT = 11;

endpackage

/* hdl/pss_event_gen.sv */
// ----------------------------------------------------------------------------
// Note-on event generator
// Jittered step probability, roll, key offset and velocity for one firing.
// ----------------------------------------------------------------------------
module pss_event_gen (
  input  logic [pss_pkg::PROB_W-1:0]  base_prob_i,
  input  logic [pss_pkg::PROB_W-1:0]  randomness_i,
  input  logic [pss_pkg::RAND_W-1:0]  rand_jitter_i,
  input  logic [pss_pkg::RAND_W-1:0]  rand_roll_i,
  input  logic [pss_pkg::SHIFT_W-1:0] rand_key_shift_i,
  input  logic [pss_pkg::VFRAC_W-1:0] vel_frac_i,
  input  logic [pss_pkg::KEY_W-1:0]   table_key_i,
  output logic                        hit_o,
  output pss_pkg::pss_event_t         event_o
);

  logic signed [17:0]              jit_off;
  logic signed [27:0]              jit_prod;
  logic signed [27:0]              prob_raw;
  logic [24:0]                     prob_clamp;
  logic [24:0]                     roll_scaled;
  logic [pss_pkg::SHIFT_W-1:0]     shift_mod;
  logic signed [8:0]               key_sum;
  logic [pss_pkg::KEY_W-1:0]       key_adj;
  logic [8:0]                      vel_t;
  logic [16:0]                     vel_prod;

  // Q1.24 probability: base*2^16 + 2*(jitter - 1/2)*randomness
  always_comb begin
    jit_off  = $signed({2'b00, rand_jitter_i}) - 18'sd32768;
    jit_prod = jit_off * $signed({1'b0, randomness_i});
    prob_raw = $signed({3'b000, base_prob_i, 16'h0000}) + (jit_prod <<< 1);
    if (prob_raw < 28'sd0) begin
      prob_clamp = '0;
    end else if (prob_raw > 28'sd16777216) begin
      prob_clamp = 25'h1000000;
    end else begin
      prob_clamp = prob_raw[24:0];
    end
    roll_scaled = {1'b0, rand_roll_i, 8'h00};
    hit_o       = roll_scaled < prob_clamp;
  end

  // key offset of -3..+3, clamped to the key range
  always_comb begin
    shift_mod = (rand_key_shift_i == pss_pkg::SHIFT_WRAP) ? '0 : rand_key_shift_i;
    key_sum   = $signed({2'b00, table_key_i}) + $signed({6'b000000, shift_mod}) - 9'sd3;
    if (key_sum < 9'sd0) begin
      key_adj = '0;
    end else if (key_sum > $signed({2'b00, pss_pkg::KEY_MAX})) begin
      key_adj = pss_pkg::KEY_MAX;
    end else begin
      key_adj = key_sum[pss_pkg::KEY_W-1:0];
    end
  end

  always_comb begin
    vel_t    = pss_pkg::VEL_BIAS + vel_frac_i;
    vel_prod = vel_t * pss_pkg::DIV10_RECIP;
    event_o.is_note_on = 1'b1;
    event_o.key        = (randomness_i > pss_pkg::RND_HALF) ? key_adj : table_key_i;
    event_o.velocity   = pss_pkg::VEL_FLOOR
                       + pss_pkg::VEL_W'(vel_prod[16:pss_pkg::DIV10_SHIFT]);
    event_o.last       = 1'b1;
  end

endmodule

/* hdl/probabilistic_step_sequencer_top.sv */
// ----------------------------------------------------------------------------
// Probabilistic step sequencer
// Input channel (in_valid_i / in_stall_o): one item per audio frame, either a
// tick (cmd 0) or a note table write (cmd 1). Output channel (out_valid_o /
// out_stall_i): note events, last_o set on the final event of a tick.
// Config channel (cfg_valid_i / cfg_ready_o): register index and data.
// Throughput is one item per cycle while intake does not stall; an accepted
// item passes an input register and is resolved from there into a four-entry
// result queue, from which its events leave. A firing tick needs two free
// queue places, so intake stalls while the queue holds three or more events
// (a tick with a release and a note-on pushes two events) or while a position
// reduction runs.
// A step_count write reduces the step position modulo the new count, one
// quotient bit per cycle; cfg_ready_o is low and no item is resolved
// meanwhile.
// Reset: counters, position and held note clear, the note table reads 60,
// registers take 6000, 16, 128 and 0. A stalled receiver holds the queue head;
// intake stalls once fewer than two queue places are free.
// ----------------------------------------------------------------------------
`include "probabilistic_step_sequencer_top_assert.svh"

module probabilistic_step_sequencer_top #(
  parameter int unsigned MAX_STEPS    = 32,
  parameter int unsigned COUNTER_BITS = 20
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // item channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              cmd_i,
  input  logic [pss_pkg::INDEX_W-1:0]       entry_index_i,
  input  logic [pss_pkg::KEY_W-1:0]         entry_note_i,
  input  logic [pss_pkg::RAND_W-1:0]        rand_jitter_i,
  input  logic [pss_pkg::RAND_W-1:0]        rand_roll_i,
  input  logic [pss_pkg::SHIFT_W-1:0]       rand_key_shift_i,
  input  logic [pss_pkg::RAND_W-1:0]        rand_level_i,
  // event channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              is_note_on_o,
  output logic [pss_pkg::KEY_W-1:0]         key_o,
  output logic [pss_pkg::VEL_W-1:0]         velocity_o,
  output logic                              last_o,
  // configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pss_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pss_pkg::SPD_W-1:0]         cfg_data_i
);

  localparam int unsigned PW  = $clog2(MAX_STEPS);
  localparam int unsigned CW  = $clog2(MAX_STEPS + 1);
  localparam int unsigned NT  = (MAX_STEPS < pss_pkg::TABLE_SLOTS) ? MAX_STEPS
                                                                   : pss_pkg::TABLE_SLOTS;
  localparam int unsigned TW  = $clog2(NT);
  localparam int unsigned CMW = (COUNTER_BITS > pss_pkg::SPD_W) ? COUNTER_BITS
                                                                : pss_pkg::SPD_W;
  localparam int unsigned RW  = 2 * PW + 1;
  localparam int unsigned KW  = (PW > 1) ? $clog2(PW) : 1;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned FIFO_ROOM  = FIFO_DEPTH - 2;

  // configuration registers
  logic [pss_pkg::SPD_W-1:0]     spd_q;
  logic [pss_pkg::STEPCNT_W-1:0] stepcnt_q;
  logic [pss_pkg::PROB_W-1:0]    base_q;
  logic [pss_pkg::PROB_W-1:0]    rnd_q;
  logic                          cfg_we;

  // input register
  logic                          in_valid_q, in_valid_d;
  logic                          in_take;
  logic                          cmd_q;
  logic [pss_pkg::INDEX_W-1:0]   idx_q;
  logic [pss_pkg::KEY_W-1:0]     note_q;
  logic [pss_pkg::RAND_W-1:0]    jit_q;
  logic [pss_pkg::RAND_W-1:0]    roll_q;
  logic [pss_pkg::SHIFT_W-1:0]   kshift_q;
  logic [pss_pkg::VFRAC_W-1:0]   vfrac_q;
  logic [24:0]                   lvl_prod;

  // sequencer state
  logic [COUNTER_BITS-1:0]       fc_q, fc_d, fc_inc;
  logic [PW-1:0]                 pos_q, pos_d, pos_nxt;
  logic [PW:0]                   pos_inc;
  logic                          note_held_q, note_held_d;
  logic [pss_pkg::KEY_W-1:0]     held_key_q, held_key_d;
  logic [pss_pkg::KEY_W-1:0]     note_tbl_q [NT];
  logic [CW-1:0]                 count_c;

  // position reduction after a step_count write
  logic                          busy_q, busy_d;
  logic [KW-1:0]                 k_q, k_d;
  logic [RW-1:0]                 red_sub;

  // stage control
  logic                          stage_go, step_en, tick_en, fire, hit, wr_en;
  logic [pss_pkg::KEY_W-1:0]     table_key;
  pss_pkg::pss_event_t           on_ev, off_ev, first_ev;
  logic                          push_off, push_on, pop;

  // result queue
  pss_pkg::pss_event_t           fifo_q [FIFO_DEPTH];
  logic [FIFO_PW-1:0]            wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0]            cnt_q;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  assign cfg_ready_o = !busy_q;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spd_q     <= pss_pkg::SPD_RESET;
      stepcnt_q <= pss_pkg::STEPCNT_RESET;
      base_q    <= pss_pkg::BASE_RESET;
      rnd_q     <= pss_pkg::RND_RESET;
    end else if (cfg_we) begin
      unique case (pss_pkg::pss_reg_e'(cfg_index_i))
        pss_pkg::REG_SAMPLES_PER_DIV: spd_q     <= cfg_data_i;
        pss_pkg::REG_STEP_COUNT:      stepcnt_q <= cfg_data_i[pss_pkg::STEPCNT_W-1:0];
        pss_pkg::REG_BASE_PROB:       base_q    <= cfg_data_i[pss_pkg::PROB_W-1:0];
        pss_pkg::REG_RANDOMNESS:      rnd_q     <= cfg_data_i[pss_pkg::PROB_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the step count to 1..MAX_STEPS
  always_comb begin
    if (stepcnt_q == '0) begin
      count_c = CW'(1);
    end else if (10'(stepcnt_q) > 10'(MAX_STEPS)) begin
      count_c = CW'(MAX_STEPS);
    end else begin
      count_c = CW'(stepcnt_q);
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  assign stage_go   = !busy_q && (cnt_q <= FIFO_CW'(FIFO_ROOM));
  assign step_en    = in_valid_q && stage_go;
  assign in_stall_o = in_valid_q && !stage_go;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_valid_d = in_stall_o ? in_valid_q : in_valid_i;

  // velocity fraction is formed on entry: floor(381*level/2^16)
  assign lvl_prod = pss_pkg::VEL_SLOPE * rand_level_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q    <= cmd_i;
      idx_q    <= entry_index_i;
      note_q   <= entry_note_i;
      jit_q    <= rand_jitter_i;
      roll_q   <= rand_roll_i;
      kshift_q <= rand_key_shift_i;
      vfrac_q  <= lvl_prod[24:16];
    end
  end

  // --------------------------------------------------------------------------
  // Step logic
  // --------------------------------------------------------------------------
  assign tick_en = step_en && (cmd_q == pss_pkg::CMD_TICK);
  assign wr_en   = step_en && (cmd_q == pss_pkg::CMD_WRITE)
                && (9'(idx_q) < 9'(MAX_STEPS));
  assign fc_inc  = fc_q + 1'b1;
  assign fire    = tick_en && (CMW'(fc_inc) >= CMW'(spd_q));

  assign pos_inc = {1'b0, pos_q} + 1'b1;
  assign pos_nxt = (pos_inc == (PW + 1)'(count_c)) ? '0 : pos_inc[PW-1:0];

  // entries beyond the writable range keep their reset key
  assign table_key = ({1'b0, pos_nxt} < (PW + 1)'(NT)) ? note_tbl_q[pos_nxt[TW-1:0]]
                                                        : pss_pkg::KEY_RESET;

  pss_event_gen u_event_gen (
    .base_prob_i      (base_q),
    .randomness_i     (rnd_q),
    .rand_jitter_i    (jit_q),
    .rand_roll_i      (roll_q),
    .rand_key_shift_i (kshift_q),
    .vel_frac_i       (vfrac_q),
    .table_key_i      (table_key),
    .hit_o            (hit),
    .event_o          (on_ev)
  );

  always_comb begin
    fc_d        = fc_q;
    pos_d       = pos_q;
    note_held_d = note_held_q;
    held_key_d  = held_key_q;
    busy_d      = busy_q;
    k_d         = k_q;
    red_sub     = RW'(count_c) << k_q;

    if (tick_en) begin
      fc_d = fire ? '0 : fc_inc;
    end
    if (fire) begin
      pos_d       = pos_nxt;
      note_held_d = hit;
      if (hit) begin
        held_key_d = on_ev.key;
      end
    end

    // restoring reduction, one quotient bit a cycle
    if (busy_q) begin
      if (RW'(pos_q) >= red_sub) begin
        pos_d = PW'(RW'(pos_q) - red_sub);
      end
      if (k_q == '0) begin
        busy_d = 1'b0;
      end else begin
        k_d = k_q - 1'b1;
      end
    end
    if (cfg_we && (cfg_index_i == pss_pkg::REG_STEP_COUNT)) begin
      busy_d = 1'b1;
      k_d    = KW'(PW - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q        <= '0;
      pos_q       <= '0;
      note_held_q <= 1'b0;
      held_key_q  <= '0;
      busy_q      <= 1'b0;
      k_q         <= '0;
    end else begin
      fc_q        <= fc_d;
      pos_q       <= pos_d;
      note_held_q <= note_held_d;
      held_key_q  <= held_key_d;
      busy_q      <= busy_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NT; i++) begin
        note_tbl_q[i] <= pss_pkg::KEY_RESET;
      end
    end else if (wr_en) begin
      note_tbl_q[idx_q[TW-1:0]] <= note_q;
    end
  end

  // --------------------------------------------------------------------------
  // Result queue
  // --------------------------------------------------------------------------
  assign push_off = fire && note_held_q;
  assign push_on  = fire && hit;

  always_comb begin
    off_ev.is_note_on = 1'b0;
    off_ev.key        = held_key_q;
    off_ev.velocity   = pss_pkg::VEL_OFF;
    off_ev.last       = !hit;
    first_ev          = push_off ? off_ev : on_ev;
  end

  assign out_valid_o  = (cnt_q != '0);
  assign pop          = out_valid_o && !out_stall_i;
  assign is_note_on_o = fifo_q[rd_ptr_q].is_note_on;
  assign key_o        = fifo_q[rd_ptr_q].key;
  assign velocity_o   = fifo_q[rd_ptr_q].velocity;
  assign last_o       = fifo_q[rd_ptr_q].last;

  always_ff @(posedge clk_i) begin
    if (push_off || push_on) begin
      fifo_q[wr_ptr_q] <= first_ev;
    end
    if (push_off && push_on) begin
      fifo_q[wr_ptr_q + 1'b1] <= on_ev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FIFO_PW'(push_off) + FIFO_PW'(push_on);
      rd_ptr_q <= rd_ptr_q + FIFO_PW'(pop);
      cnt_q    <= cnt_q + FIFO_CW'(push_off) + FIFO_CW'(push_on) - FIFO_CW'(pop);
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `PSS_ASSERT_IMPL(a_room_for_step, step_en, cnt_q <= FIFO_CW'(FIFO_ROOM),
                   "item resolved without two free queue places")
  `PSS_ASSERT_IMPL(a_no_step_reducing, busy_q, !step_en,
                   "item resolved during position reduction")
  `PSS_ASSERT_IMPL(a_pos_in_range, !busy_q, (PW + 1)'(pos_q) < (PW + 1)'(count_c),
                   "step position at or above the step count")
  `PSS_ASSERT_NEXT(a_hit_holds_note, fire && hit,
                   note_held_q && (held_key_q == $past(on_ev.key)),
                   "note on not recorded as held")
  `PSS_ASSERT_IMPL(a_queue_bound, 1'b1, cnt_q <= FIFO_CW'(FIFO_DEPTH),
                   "result queue overflow")

endmodule
